FILE: hdl/qrm_pkg.sv
`default_nettype none
package qrm_pkg;

  // default number of newton iterations for the reciprocal square root
  localparam int RSQRT_STEPS_DEF = 3;

  // pipeline depth of one newton iteration
  localparam int NEWTON_STAGES = 4;

  // configuration register indexes
  typedef enum logic {
    REG_CLEAN_THRESHOLD = 1'b0
  } reg_index_t;

  // one in q2.14
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               zero_input;
  } mat_t;

  // seed of the reciprocal square root, q2.14, by the top four bits of the normalized sum
  function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
    logic [15:0] s;
    case (idx)
      4'd5:    s = 16'd27945;
      4'd6:    s = 16'd25705;
      4'd7:    s = 16'd23930;
      4'd8:    s = 16'd22479;
      4'd9:    s = 16'd21263;
      4'd10:   s = 16'd20225;
      4'd11:   s = 16'd19326;
      4'd12:   s = 16'd18536;
      4'd13:   s = 16'd17837;
      4'd14:   s = 16'd17211;
      4'd15:   s = 16'd16646;
      default: s = 16'd30894;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/qrm_newton_step.sv
`default_nettype none
module qrm_newton_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        src_valid,
  input  logic [31:0] src_r,
  input  logic [29:0] src_t4,
  output logic        dst_valid,
  output logic [31:0] dst_r,
  output logic [29:0] dst_t4
);
  import qrm_pkg::*;

  localparam logic [33:0] THREE = 34'h0C000_0000;

  logic        va, vb, vc;
  logic [31:0] ra, rb, rc;
  logic [29:0] ta, tb, tc;
  logic [33:0] y2a;
  logic [46:0] plo, phi;
  logic [31:0] fc;

  logic [63:0] prod_rr;
  logic [63:0] prod_my;
  logic [33:0] my2;
  logic [31:0] f;
  logic [63:0] prod_rf;
  logic [32:0] rn;

  // y squared
  assign prod_rr = src_r * src_r;
  // m*y^2 from two partial products
  assign prod_my = 64'(plo) + {phi, 17'b0};
  assign my2     = prod_my[63:30];
  assign f       = (my2 >= THREE) ? 32'd0 : 32'(THREE - my2);
  // y*(3-m*y^2)/2 with saturation
  assign prod_rf = rc * fc;
  assign rn      = prod_rf[63:31];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      va        <= src_valid;
      vb        <= va;
      vc        <= vb;
      dst_valid <= vc;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      ra     <= src_r;
      ta     <= src_t4;
      y2a    <= prod_rr[63:30];
      rb     <= ra;
      tb     <= ta;
      plo    <= ta * y2a[16:0];
      phi    <= ta * y2a[33:17];
      rc     <= rb;
      tc     <= tb;
      fc     <= f;
      dst_t4 <= tc;
      dst_r  <= rn[32] ? 32'hFFFF_FFFF : rn[31:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/quaternion_to_rotation_matrix_unit.sv
`default_nettype none
// quaternion to 3x3 rotation matrix
// input channel quat_valid/quat_stall/quat carries one quaternion (w,x,y,z)
// in signed q2.14; output channel mat_valid/mat_stall/mat carries the nine
// matrix entries in q2.14 plus zero_input. a transaction moves on an edge
// with valid high and stall low. each quaternion gives exactly one matrix.
// the stages are squares, sum, shift count, seed, four stages per newton
// iteration, then scaling, products, sums and the output register. one
// transaction per cycle is sustained while mat_stall is low; every
// multiplier sits alone between registers.
// the apb port holds clean_threshold at address 0; entries of magnitude
// below it become zero. a zero quaternion gives the identity matrix.
// reset clears all valid bits and the threshold. while mat_valid is high
// and mat_stall is high the whole pipeline holds and quat_stall is raised;
// nothing is lost or repeated.
module quaternion_to_rotation_matrix_unit #(
  parameter int RSQRT_STEPS = qrm_pkg::RSQRT_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          quat_valid,
  output logic          quat_stall,
  input  qrm_pkg::quat_t quat,
  output logic          mat_valid,
  input  logic          mat_stall,
  output qrm_pkg::mat_t mat,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import qrm_pkg::*;

  localparam int NSTG = NEWTON_STAGES * RSQRT_STEPS;

  typedef struct packed {
    quat_t      q;
    logic [4:0] k;
    logic       zero;
  } side_t;

  logic       en;
  logic [9:0] clean_threshold;
  reg_index_t reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[2]);
  assign prdata  = (reg_idx == REG_CLEAN_THRESHOLD) ? {22'b0, clean_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clean_threshold <= 10'd0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_CLEAN_THRESHOLD) begin
      clean_threshold <= pwdata[9:0];
    end
  end

  // global pipeline advance
  assign en         = !(mat_valid && mat_stall);
  assign quat_stall = !en;

  // stage 1: squares
  logic        v1;
  quat_t       q1;
  logic [30:0] sq1 [4];

  // stage 2: sum of squares
  logic        v2;
  quat_t       q2;
  logic [32:0] sum2;

  // stage 3: shift count
  logic        v3;
  logic [32:0] sum3;
  side_t       sd3;
  logic [4:0]  k_next;

  // stage 4: normalized sum and seed
  logic        v4;
  side_t       sd4;
  logic [29:0] t4_4;
  logic [31:0] r4;
  logic [65:0] t_full;

  always_comb begin
    k_next = 5'd16;
    for (int j = 16; j >= 0; j--) begin
      if ((sum2 >> (32 - 2 * j)) != 33'd0) k_next = 5'(j);
    end
  end

  assign t_full = {33'b0, sum3} << {sd3.k, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= quat_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1     <= quat;
      sq1[0] <= 31'(quat.quat_w * quat.quat_w);
      sq1[1] <= 31'(quat.quat_x * quat.quat_x);
      sq1[2] <= 31'(quat.quat_y * quat.quat_y);
      sq1[3] <= 31'(quat.quat_z * quat.quat_z);
      q2     <= q1;
      sum2   <= 33'(sq1[0]) + 33'(sq1[1]) + 33'(sq1[2]) + 33'(sq1[3]);
      sum3   <= sum2;
      sd3.q    <= q2;
      sd3.k    <= k_next;
      sd3.zero <= (sum2 == 33'd0);
      sd4    <= sd3;
      t4_4   <= t_full[33:4];
      r4     <= {rsqrt_seed(t_full[33:30]), 16'b0};
    end
  end

  // newton iterations
  logic        nv  [RSQRT_STEPS + 1];
  logic [31:0] nr  [RSQRT_STEPS + 1];
  logic [29:0] nt4 [RSQRT_STEPS + 1];

  assign nv[0]  = v4;
  assign nr[0]  = r4;
  assign nt4[0] = t4_4;

  for (genvar g = 0; g < RSQRT_STEPS; g++) begin : g_step
    qrm_newton_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (nv[g]),
      .src_r     (nr[g]),
      .src_t4    (nt4[g]),
      .dst_valid (nv[g + 1]),
      .dst_r     (nr[g + 1]),
      .dst_t4    (nt4[g + 1])
    );
  end

  // side data follows the newton chain
  side_t sd_dly [NSTG];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_dly[0] <= sd4;
      for (int i = 1; i < NSTG; i++) sd_dly[i] <= sd_dly[i - 1];
    end
  end

  side_t sdn;
  logic  [31:0] rr;
  assign sdn = sd_dly[NSTG - 1];
  assign rr  = nr[RSQRT_STEPS];

  // sign of component i of the side data
  function automatic logic qc5_sign(input side_t s, input int i);
    logic b;
    case (i)
      0:       b = s.q.quat_w[15];
      1:       b = s.q.quat_x[15];
      2:       b = s.q.quat_y[15];
      default: b = s.q.quat_z[15];
    endcase
    return b;
  endfunction

  // stage 5: component magnitude times rsqrt
  logic        v5;
  side_t       sd5;
  logic [48:0] p5 [4];
  logic [16:0] mag [4];
  logic signed [15:0] qc [4];

  assign qc[0] = sdn.q.quat_w;
  assign qc[1] = sdn.q.quat_x;
  assign qc[2] = sdn.q.quat_y;
  assign qc[3] = sdn.q.quat_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = qc[i][15] ? 17'(-17'(qc[i])) : 17'(qc[i]);
    end
  end

  // stage 6: round, shift and limit to q1.30
  logic              v6;
  side_t             sd6;
  logic signed [31:0] n6 [4];
  logic [4:0]        sh;
  logic [49:0]       rnd [4];
  logic [49:0]       pr  [4];
  logic [30:0]       pc  [4];

  assign sh = 5'd17 - sd5.k;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i] = 50'(p5[i]) + (50'd1 << (sh - 5'd1));
      pr[i]  = rnd[i] >> sh;
      pc[i]  = (pr[i] > 50'h0_0000_4000_0000) ? 31'h4000_0000 : pr[i][30:0];
    end
  end

  // stage 7: pairwise products in q.60
  logic              v7;
  logic              zero7;
  logic signed [63:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;

  // stage 8: matrix entries in q.60
  logic              v8;
  logic              zero8;
  logic signed [63:0] e8 [9];
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v5 <= nv[RSQRT_STEPS];
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5 <= sdn;
      for (int i = 0; i < 4; i++) p5[i] <= mag[i] * rr;
      sd6 <= sd5;
      for (int i = 0; i < 4; i++) begin
        n6[i] <= qc5_sign(sd5, i) ? -32'(signed'({1'b0, pc[i]})) : 32'(signed'({1'b0, pc[i]}));
      end
      zero7 <= sd6.zero;
      xx <= n6[1] * n6[1];
      xy <= n6[1] * n6[2];
      xz <= n6[1] * n6[3];
      xw <= n6[1] * n6[0];
      yy <= n6[2] * n6[2];
      yz <= n6[2] * n6[3];
      yw <= n6[2] * n6[0];
      zz <= n6[3] * n6[3];
      zw <= n6[3] * n6[0];
      zero8 <= zero7;
      e8[0] <= ONE_Q60 - ((yy + zz) <<< 1);
      e8[1] <= (xy - zw) <<< 1;
      e8[2] <= (xz + yw) <<< 1;
      e8[3] <= (xy + zw) <<< 1;
      e8[4] <= ONE_Q60 - ((xx + zz) <<< 1);
      e8[5] <= (yz - xw) <<< 1;
      e8[6] <= (xz - yw) <<< 1;
      e8[7] <= (yz + xw) <<< 1;
      e8[8] <= ONE_Q60 - ((xx + yy) <<< 1);
    end
  end

  // stage 9: round to q2.14, saturate, force identity for a zero input, clean small entries
  logic [63:0]        u9  [9];
  logic signed [17:0] rq  [9];
  logic signed [15:0] rs  [9];
  logic signed [15:0] rf  [9];
  logic [16:0]        ab  [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      u9[i] = 64'(e8[i]) + (64'd1 << 45);
      rq[i] = signed'(u9[i][63:46]);
      if (rq[i] > 18'sd32767)       rs[i] = 16'sh7FFF;
      else if (rq[i] < -18'sd32768) rs[i] = 16'sh8000;
      else                          rs[i] = rq[i][15:0];
      if (zero8) rs[i] = (i % 4 == 0) ? ONE_Q14 : 16'sd0;
      ab[i] = rs[i][15] ? 17'(-17'(rs[i])) : 17'(rs[i]);
      rf[i] = (ab[i] < 17'(clean_threshold)) ? 16'sd0 : rs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (en) begin
      mat_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat.r00        <= rf[0];
      mat.r01        <= rf[1];
      mat.r02        <= rf[2];
      mat.r10        <= rf[3];
      mat.r11        <= rf[4];
      mat.r12        <= rf[5];
      mat.r20        <= rf[6];
      mat.r21        <= rf[7];
      mat.r22        <= rf[8];
      mat.zero_input <= zero8;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/qrm_checker.sv
`default_nettype none
module qrm_checker (
  input logic          clk,
  input logic          rst,
  input logic          quat_stall,
  input logic          mat_valid,
  input logic          mat_stall,
  input qrm_pkg::mat_t mat
);
  import qrm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    mat_valid && mat_stall |=> mat_valid && $stable(mat))
    else $error("stalled result changed");

  // input is only held back by a stalled result
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    quat_stall |-> mat_valid && mat_stall)
    else $error("input stalled without output back-pressure");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !mat_valid)
    else $error("result valid after reset");

  // zero quaternion gives identity
  a_identity: assert property (@(posedge clk) disable iff (rst)
    mat_valid && mat.zero_input |->
      mat.r00 == ONE_Q14 && mat.r11 == ONE_Q14 && mat.r22 == ONE_Q14 &&
      mat.r01 == 16'sd0 && mat.r02 == 16'sd0 && mat.r10 == 16'sd0 &&
      mat.r12 == 16'sd0 && mat.r20 == 16'sd0 && mat.r21 == 16'sd0)
    else $error("zero quaternion did not give identity");

endmodule

bind quaternion_to_rotation_matrix_unit qrm_checker u_qrm_checker (
  .clk        (clk),
  .rst        (rst),
  .quat_stall (quat_stall),
  .mat_valid  (mat_valid),
  .mat_stall  (mat_stall),
  .mat        (mat)
);
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import qrm_pkg::*;

  localparam int LATENCY = 9 + 4 * RSQRT_STEPS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quat_valid = 1'b0;
  logic quat_stall;
  quat_t quat = '0;
  logic mat_valid;
  logic mat_stall = 1'b0;
  mat_t mat;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quaternion_to_rotation_matrix_unit dut (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // testbench state
  quat_t pending_quats[$];
  mat_t expected_mats[$];
  logic [9:0] threshold_model = '0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_len = 0;
  int hold_off_done = 0;
  int idle_cycles = 0;

  // matrix predictor
  function automatic logic signed [15:0] entry_to_q14(logic signed [63:0] v);
    logic [63:0] u;
    longint r;
    u = v + (64'd1 << 62) + (64'd1 << 45);
    r = longint'(u >> 46) - 65536;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    if ((r < 0 ? -r : r) < longint'(threshold_model)) r = 0;
    return 16'(r);
  endfunction

  function automatic longint normalize_comp(longint q, logic [63:0] rs, int sh);
    logic [63:0] mag, p;
    mag = (q < 0) ? -q : q;
    p = (mag * rs + (64'd1 << (sh - 1))) >> sh;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    return (q < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic mat_t predict_matrix(quat_t q);
    logic [15:0] seeds[16] = '{30894, 30894, 30894, 30894, 30894, 27945, 25705, 23930,
                               22479, 21263, 20225, 19326, 18536, 17837, 17211, 16646};
    longint w, x, y, z, nw, nx, ny, nz;
    longint e[9];
    logic [63:0] sumsq, t, rs, y2, my2, f;
    int k;
    mat_t m;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    sumsq = w * w + x * x + y * y + z * z;
    if (sumsq == 0) begin
      foreach (e[i]) e[i] = (i % 4 == 0) ? (64'sd1 <<< 60) : 0;
      m.zero_input = 1'b1;
    end else begin
      t = sumsq;
      k = 0;
      while (t < (64'd1 << 32) && k < 16) begin
        t = t << 2;
        k++;
      end
      rs = 64'(seeds[(t >> 30) & 15]) << 16;
      for (int i = 0; i < RSQRT_STEPS_DEF; i++) begin
        y2 = (rs * rs) >> 30;
        my2 = ((t >> 4) * y2) >> 30;
        f = (my2 >= (64'd3 << 30)) ? 0 : (64'd3 << 30) - my2;
        rs = (rs * f) >> 31;
        if (rs > 64'hFFFF_FFFF) rs = 64'hFFFF_FFFF;
      end
      nw = normalize_comp(w, rs, 17 - k);
      nx = normalize_comp(x, rs, 17 - k);
      ny = normalize_comp(y, rs, 17 - k);
      nz = normalize_comp(z, rs, 17 - k);
      e[0] = (64'sd1 <<< 60) - 2 * (ny * ny + nz * nz);
      e[1] = 2 * (nx * ny - nz * nw);
      e[2] = 2 * (nx * nz + ny * nw);
      e[3] = 2 * (nx * ny + nz * nw);
      e[4] = (64'sd1 <<< 60) - 2 * (nx * nx + nz * nz);
      e[5] = 2 * (ny * nz - nx * nw);
      e[6] = 2 * (nx * nz - ny * nw);
      e[7] = 2 * (ny * nz + nx * nw);
      e[8] = (64'sd1 <<< 60) - 2 * (nx * nx + ny * ny);
      m.zero_input = 1'b0;
    end
    m.r00 = entry_to_q14(e[0]); m.r01 = entry_to_q14(e[1]); m.r02 = entry_to_q14(e[2]);
    m.r10 = entry_to_q14(e[3]); m.r11 = entry_to_q14(e[4]); m.r12 = entry_to_q14(e[5]);
    m.r20 = entry_to_q14(e[6]); m.r21 = entry_to_q14(e[7]); m.r22 = entry_to_q14(e[8]);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver; the front of the queue is the transaction on the bus until accepted
  always @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else begin
      if (quat_valid && !quat_stall) begin
        expected_mats.push_back(predict_matrix(quat));
        void'(pending_quats.pop_front());
      end
      if (quat_valid && quat_stall) begin
        // hold the stalled transaction
      end else if (pending_quats.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        quat_valid <= 1'b1;
        quat <= pending_quats[0];
      end else begin
        quat_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst && mat_valid && !mat_stall) begin
      if (expected_mats.size() == 0) begin
        report_mismatch("unexpected matrix", 1, 0);
      end else begin
        mat_t want;
        want = expected_mats.pop_front();
        if (mat.r00 !== want.r00) report_mismatch("r00", mat.r00, want.r00);
        if (mat.r01 !== want.r01) report_mismatch("r01", mat.r01, want.r01);
        if (mat.r02 !== want.r02) report_mismatch("r02", mat.r02, want.r02);
        if (mat.r10 !== want.r10) report_mismatch("r10", mat.r10, want.r10);
        if (mat.r11 !== want.r11) report_mismatch("r11", mat.r11, want.r11);
        if (mat.r12 !== want.r12) report_mismatch("r12", mat.r12, want.r12);
        if (mat.r20 !== want.r20) report_mismatch("r20", mat.r20, want.r20);
        if (mat.r21 !== want.r21) report_mismatch("r21", mat.r21, want.r21);
        if (mat.r22 !== want.r22) report_mismatch("r22", mat.r22, want.r22);
        if (mat.zero_input !== want.zero_input)
          report_mismatch("zero_input", mat.zero_input, want.zero_input);
      end
    end
    if (hold_off_done < hold_off_len) begin
      hold_off_done <= hold_off_done + 1;
      mat_stall <= 1'b1;
    end else begin
      mat_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (quat_valid && !quat_stall) || (mat_valid && !mat_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_threshold(logic [9:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_CLEAN_THRESHOLD) << 2; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold_model = value;
  endtask

  task automatic drain_all();
    while (pending_quats.size() > 0 || quat_valid || expected_mats.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] random_comp();
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'(int'($urandom_range(32)) - 16);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic queue_random(int count);
    quat_t q;
    for (int i = 0; i < count; i++) begin
      q.quat_w = random_comp(); q.quat_x = random_comp();
      q.quat_y = random_comp(); q.quat_z = random_comp();
      if ($urandom_range(40) == 0) q = '0;
      pending_quats.push_back(q);
    end
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: zero, unit axes, extremes, tiny values, mixed values
    pending_quats.push_back('0);
    pending_quats.push_back('{16384, 0, 0, 0});
    pending_quats.push_back('{0, 16384, 0, 0});
    pending_quats.push_back('{0, 0, 16384, 0});
    pending_quats.push_back('{0, 0, 0, 16384});
    pending_quats.push_back('{-16384, 0, 0, 0});
    pending_quats.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_quats.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    pending_quats.push_back('{1, 0, 0, 0});
    pending_quats.push_back('{0, 0, 0, -1});
    pending_quats.push_back('{1, 1, 1, 1});
    pending_quats.push_back('{11585, 11585, 0, 0});
    pending_quats.push_back('{8192, 8192, 8192, 8192});
    pending_quats.push_back('{16'shFFFF, 16'shAAAA, 16'sh5555, 16'sh0001});
    drain_all();
    write_threshold(10'd1023);
    pending_quats.push_back('0);
    pending_quats.push_back('{16384, 1000, 20, 3});
    queue_random(100);
    drain_all();
    write_threshold(10'd7);
    // no idling
    queue_random(200);
    drain_all();
    // sender idle
    send_idle_pct = 68;
    queue_random(200);
    drain_all();
    write_threshold(10'd300);
    // receiver stalls
    send_idle_pct = 0; recv_stall_pct = 68;
    queue_random(200);
    drain_all();
    // both
    send_idle_pct = 28; recv_stall_pct = 28;
    write_threshold(10'd0);
    queue_random(200);
    drain_all();
    // long hold-off so the pipeline fills and back-pressures
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off_len = 150;
    queue_random(150);
    drain_all();
    if (prdata !== 32'(threshold_model))
      report_mismatch("threshold readback", int'(prdata), int'(threshold_model));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
